FILE: rtl/geq_pkg.sv
package geq_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int BANDS_DEF    = 10;

	localparam logic [3:0]  ACTIVE_BANDS_RST = 4'd10;
	localparam logic [15:0] OUTPUT_SCALE_RST = 16'd16384;

	localparam logic signed [17:0] FIXED_B1 = -18'sd16466;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANDS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 1'd1;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_COEF   = 2'd1,
		CMD_GAIN   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		SEL_A0 = 2'd0,
		SEL_A1 = 2'd1,
		SEL_B0 = 2'd2
	} coef_sel_t;

	typedef struct packed {
		logic signed [17:0] a0;
		logic signed [17:0] a1;
		logic signed [17:0] b0;
	} coef_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B0,
		ST_A0,
		ST_A1,
		ST_B1,
		ST_WS,
		ST_TA,
		ST_TS,
		ST_G,
		ST_YU,
		ST_OS,
		ST_OUT
	} state_t;

	// round half up by 2^-14, then saturate to 32 bit
	function automatic logic signed [31:0] rnd_sat32(input logic signed [51:0] v);
		logic signed [51:0] s;
		logic [37:0] r;
		s = v + 52'sd8192;
		r = s[51:14];
		if (r[37] && !(&r[36:31])) begin
			return 32'sh8000_0000;
		end else if (!r[37] && (|r[36:31])) begin
			return 32'sh7fff_ffff;
		end
		return $signed(r[31:0]);
	endfunction

	// y plus rounded product, saturated to 32 bit
	function automatic logic signed [31:0] add_sat32(input logic signed [31:0] y,
			input logic signed [49:0] p);
		logic signed [49:0] s;
		logic signed [35:0] r;
		logic signed [36:0] t;
		s = p + 50'sd8192;
		r = $signed(s[49:14]);
		t = 37'(y) + 37'(r);
		if (t[36] && !(&t[35:31])) begin
			return 32'sh8000_0000;
		end else if (!t[36] && (|t[35:31])) begin
			return 32'sh7fff_ffff;
		end
		return t[31:0];
	endfunction

	// rounded product saturated to 24 bit
	function automatic logic signed [23:0] rnd_sat24(input logic signed [49:0] p);
		logic signed [49:0] s;
		logic [35:0] r;
		s = p + 50'sd8192;
		r = s[49:14];
		if (r[35] && !(&r[34:23])) begin
			return 24'sh80_0000;
		end else if (!r[35] && (|r[34:23])) begin
			return 24'sh7f_ffff;
		end
		return $signed(r[23:0]);
	endfunction

endpackage

FILE: rtl/graphic_equalizer_iir_cascade.sv
// channel  | signals                                            | dir
// ---------+----------------------------------------------------+-----
// request  | req_valid, req_stall, command, channel, band,      | in
//          | coef_select, sample_in                             |
// response | rsp_valid, rsp_stall, sample_out                   | out
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data          | in
//
// a coefficient or gain write is stored at its accept; a sample word runs through
// the band steps for each of n bands, then output scaling, into the result register,
// n the bands run; one shared 32x18 multiplier, nine steps per band
// arst_n resets the config registers to defaults, clears the coefficient table
// and the valid bits of the filter memory and gain memory; no clearing pass is needed
// req_stall is high while a sample is in work; a stalled result holds the block
module graphic_equalizer_iir_cascade #(
	parameter int CHANNELS = geq_pkg::CHANNELS_DEF,
	parameter int BANDS    = geq_pkg::BANDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    command,
	input  logic [2:0]                    channel,
	input  logic [3:0]                    band,
	input  logic [1:0]                    coef_select,
	input  logic signed [23:0]            sample_in,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic signed [23:0]            sample_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [geq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);

	localparam int ROWS = CHANNELS * BANDS;
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW   = $clog2(BANDS + 1);
	localparam int BIW  = (BANDS > 1) ? $clog2(BANDS) : 1;

	geq_pkg::state_t state_q, state_d;

	logic [3:0]  active_q;
	logic [15:0] scale_q;

	geq_pkg::coef_t coef_q [BANDS];

	logic [63:0]        row_mem [ROWS];
	logic [ROWS-1:0]    row_vld_q;
	logic signed [17:0] gain_mem [ROWS];
	logic [ROWS-1:0]    gain_vld_q;

	logic [63:0]        row_rd_q;
	logic               row_rdv_q;
	logic signed [17:0] gain_rd_q;
	logic               gain_rdv_q;

	logic [AW-1:0] addr_q;
	logic [CW-1:0] k_q, nb_q, nb_in;

	logic signed [31:0] y_q, m0_q, m1_q, w_q, t_q;
	logic signed [17:0] g_q;
	logic signed [51:0] acc_q;
	logic signed [49:0] prod_q, mul_p;
	logic signed [31:0] mul_a;
	logic signed [17:0] mul_b;
	logic               mul_en;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               req_acc, ch_ok, band_ok;
	logic [AW-1:0]      base_row, gw_addr;
	logic signed [17:0] wr_val;
	logic [CW-1:0]      k_next;
	logic [BIW-1:0]     kidx, bidx;
	logic               rsp_valid_q;
	logic signed [23:0] sample_out_q;

	assign req_stall  = (state_q != geq_pkg::ST_IDLE);
	assign req_acc    = req_valid && !req_stall;
	assign cfg_ready  = 1'b1;
	assign rsp_valid  = rsp_valid_q;
	assign sample_out = sample_out_q;

	assign ch_ok    = (32'(channel) < CHANNELS);
	assign band_ok  = (32'(band) < BANDS);
	assign base_row = AW'(32'(channel) * BANDS);
	assign gw_addr  = AW'(32'(channel) * BANDS + 32'(band));
	assign wr_val   = $signed(sample_in[17:0]);
	assign nb_in    = (32'(active_q) > BANDS) ? CW'(BANDS) : CW'(active_q);
	assign k_next   = k_q + CW'(1);
	assign kidx     = k_q[BIW-1:0];
	assign bidx     = band[BIW-1:0];

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= geq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = addr_q;
		mul_en  = 1'b0;
		mul_a   = y_q;
		mul_b   = '0;
		case (state_q)
			geq_pkg::ST_IDLE: begin
				if (req_acc && command == geq_pkg::CMD_SAMPLE && ch_ok) begin
					rd_en   = 1'b1;
					rd_addr = base_row;
					state_d = (nb_in == '0) ? geq_pkg::ST_OS : geq_pkg::ST_B0;
				end
			end
			geq_pkg::ST_B0: begin
				mul_en  = 1'b1;
				mul_a   = y_q;
				mul_b   = coef_q[kidx].b0;
				state_d = geq_pkg::ST_A0;
			end
			geq_pkg::ST_A0: begin
				mul_en  = 1'b1;
				mul_a   = m0_q;
				mul_b   = coef_q[kidx].a0;
				state_d = geq_pkg::ST_A1;
			end
			geq_pkg::ST_A1: begin
				mul_en  = 1'b1;
				mul_a   = m1_q;
				mul_b   = coef_q[kidx].a1;
				state_d = geq_pkg::ST_B1;
			end
			geq_pkg::ST_B1: begin
				mul_en  = 1'b1;
				mul_a   = m1_q;
				mul_b   = geq_pkg::FIXED_B1;
				state_d = geq_pkg::ST_WS;
			end
			geq_pkg::ST_WS: begin
				state_d = geq_pkg::ST_TA;
			end
			geq_pkg::ST_TA: begin
				state_d = geq_pkg::ST_TS;
			end
			geq_pkg::ST_TS: begin
				state_d = geq_pkg::ST_G;
			end
			geq_pkg::ST_G: begin
				mul_en  = 1'b1;
				mul_a   = t_q;
				mul_b   = g_q;
				state_d = geq_pkg::ST_YU;
			end
			geq_pkg::ST_YU: begin
				if (k_next == nb_q) begin
					state_d = geq_pkg::ST_OS;
				end else begin
					rd_en   = 1'b1;
					rd_addr = addr_q + AW'(1);
					state_d = geq_pkg::ST_B0;
				end
			end
			geq_pkg::ST_OS: begin
				mul_en  = 1'b1;
				mul_a   = y_q;
				mul_b   = $signed({2'b00, scale_q});
				state_d = geq_pkg::ST_OUT;
			end
			geq_pkg::ST_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = geq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = geq_pkg::ST_IDLE;
			end
		endcase
	end

	// config, coefficient table, valid bits, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= geq_pkg::ACTIVE_BANDS_RST;
			scale_q     <= geq_pkg::OUTPUT_SCALE_RST;
			coef_q      <= '{default: '0};
			row_vld_q   <= '0;
			gain_vld_q  <= '0;
			rsp_valid_q <= 1'b0;
			addr_q      <= '0;
			k_q         <= '0;
			nb_q        <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					geq_pkg::CFG_ACTIVE_BANDS: active_q <= cfg_data[3:0];
					geq_pkg::CFG_OUTPUT_SCALE: scale_q  <= cfg_data;
					default: ;
				endcase
			end
			if (req_acc) begin
				case (command)
					geq_pkg::CMD_SAMPLE: begin
						addr_q <= base_row;
						k_q    <= '0;
						nb_q   <= nb_in;
					end
					geq_pkg::CMD_COEF: begin
						if (band_ok) begin
							case (coef_select)
								geq_pkg::SEL_A0: coef_q[bidx].a0 <= wr_val;
								geq_pkg::SEL_A1: coef_q[bidx].a1 <= wr_val;
								geq_pkg::SEL_B0: coef_q[bidx].b0 <= wr_val;
								default: ;
							endcase
						end
					end
					geq_pkg::CMD_GAIN: begin
						if (band_ok && ch_ok) begin
							gain_vld_q[gw_addr] <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == geq_pkg::ST_YU) begin
				row_vld_q[addr_q] <= 1'b1;
				k_q               <= k_next;
				if (rd_en) begin
					addr_q <= rd_addr;
				end
			end
			if (state_q == geq_pkg::ST_OUT && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// filter memory and gain memory
	always_ff @(posedge clk) begin
		if (req_acc && command == geq_pkg::CMD_GAIN && band_ok && ch_ok) begin
			gain_mem[gw_addr] <= wr_val;
		end
		if (state_q == geq_pkg::ST_YU) begin
			row_mem[addr_q] <= {m0_q, w_q};
		end
		if (rd_en) begin
			row_rd_q   <= row_mem[rd_addr];
			row_rdv_q  <= row_vld_q[rd_addr];
			gain_rd_q  <= gain_mem[rd_addr];
			gain_rdv_q <= gain_vld_q[rd_addr];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_p;
		end
		case (state_q)
			geq_pkg::ST_IDLE: begin
				if (req_acc) begin
					y_q <= 32'(sample_in);
				end
			end
			geq_pkg::ST_B0: begin
				m0_q <= row_rdv_q ? $signed(row_rd_q[31:0]) : '0;
				m1_q <= row_rdv_q ? $signed(row_rd_q[63:32]) : '0;
				g_q  <= gain_rdv_q ? gain_rd_q : '0;
			end
			geq_pkg::ST_A0: acc_q <= 52'(prod_q);
			geq_pkg::ST_A1: acc_q <= acc_q + 52'(prod_q);
			geq_pkg::ST_B1: acc_q <= acc_q + 52'(prod_q);
			geq_pkg::ST_WS: w_q <= geq_pkg::rnd_sat32(acc_q);
			geq_pkg::ST_TA: acc_q <= (52'(w_q) <<< 14) + 52'(prod_q);
			geq_pkg::ST_TS: t_q <= geq_pkg::rnd_sat32(acc_q);
			geq_pkg::ST_YU: y_q <= geq_pkg::add_sat32(y_q, prod_q);
			geq_pkg::ST_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					sample_out_q <= geq_pkg::rnd_sat24(prod_q);
				end
			end
			default: ;
		endcase
	end

endmodule
